// ===== rtl/core/greedy_line_filler_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the greedy line filler
// Each macro expands to a clocked concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef GREEDY_LINE_FILLER_TOP_ASSERT_SVH
`define GREEDY_LINE_FILLER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The property holds at every clock edge out of reset.
`define GLF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("greedy line filler: invariant violated");

// When the condition holds, the consequence holds in the next cycle.
`define GLF_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("greedy line filler: next-cycle check violated");

`else

`define GLF_ASSERT_ALWAYS(lbl, prop)
`define GLF_ASSERT_NEXT(lbl, cond, cons)

`endif

`endif

// ===== rtl/core/glf_pkg.sv =====
// ---------------------------------------------------------------------------
// glf_pkg
// Shared constants and types of the greedy line filler.
// ---------------------------------------------------------------------------
package glf_pkg;

  // Character codes.
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  // Line length and adder widths.
  localparam int LINE_W = 9;
  localparam int SUM_W  = LINE_W + 1;
  // Width used for word limit compares (holds up to 127).
  localparam int LIM_W  = 7;

  // Configuration registers.
  localparam int              CFG_IDX_W      = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LIMIT = 2'd1;
  localparam logic [7:0]      LINE_LIMIT_RST = 8'd60;
  localparam logic [5:0]      WORD_LIMIT_RST = 6'd30;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_NL,
    ST_WORD,
    ST_SPACE
  } state_t;

  // Result of the shared add and compare unit.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             gt;
    logic             eq;
  } alu_res_t;

  // Space, tab, CR and LF count as whitespace.
  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

// ===== rtl/core/glf_alu.sv =====
// ---------------------------------------------------------------------------
// glf_alu
// Shared adder with compare against a limit, used by the prep, word and space steps.
// ---------------------------------------------------------------------------
module glf_alu (
  input  logic [glf_pkg::LINE_W-1:0] a,
  input  logic [glf_pkg::LINE_W-1:0] b,
  input  logic [glf_pkg::LINE_W-1:0] c,
  output glf_pkg::alu_res_t          res
);
  import glf_pkg::*;

  logic [SUM_W-1:0] sum;

  // One add, then greater-than and equal against the limit operand.
  assign sum     = {1'b0, a} + {1'b0, b};
  assign res.sum = sum;
  assign res.gt  = sum > {1'b0, c};
  assign res.eq  = sum == {1'b0, c};

endmodule

// ===== rtl/core/glf_store.sv =====
// ---------------------------------------------------------------------------
// glf_store
// Word store: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module glf_store #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  import glf_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write the incoming word byte.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/greedy_line_filler_top.sv =====
// ---------------------------------------------------------------------------
// greedy_line_filler_top
// Greedy word wrap over a byte stream with a word store and a sequencer.
// ---------------------------------------------------------------------------
// One text byte is taken per item. A byte that does not end a word is taken
// while the block is idle and yields no output. A byte that flushes a word
// keeps the input stalled while the sequencer checks the line length, emits
// a newline if the line is full, then the word and a trailing space; output
// stalls add to that. The sequencer emits one byte per cycle into the output
// register while the output does not stall, reading the word store through
// its single registered read port and stepping its index and line length
// through one shared adder. Configuration writes are always taken and
// should only be issued while the block is idle.
module greedy_line_filler_top #(
  parameter int WORD_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Text input.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_text_byte,
  input  logic                           in_end_of_text,
  // Wrapped output.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_run_last,
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [glf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);
  import glf_pkg::*;

  localparam int CW = $clog2(WORD_DEPTH + 1);
  localparam int AW = $clog2(WORD_DEPTH);

  // Registers.
  state_t              state_r, state_nxt;
  logic [7:0]          line_limit_r;
  logic [5:0]          word_limit_r;
  logic [CW-1:0]       word_cnt_r;
  logic [LINE_W-1:0]   line_r;
  logic                in_gap_r;
  logic                seen_first_r;
  logic [CW-1:0]       len_r;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [LINE_W-1:0]   base_r, base_nxt;
  logic                end_r;
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_last_r;

  // Combinational signals.
  logic                in_acc;
  logic                ws;
  logic [CW-1:0]       cnt_store;
  logic [LIM_W-1:0]    wl_ext;
  logic [LIM_W-1:0]    wl_eff;
  logic                split;
  logic                first_flush;
  logic [CW-1:0]       cnt_after;
  logic                flush;
  logic                st_wr;
  logic                load;
  logic                emit;
  logic [7:0]          emit_byte;
  logic                emit_last;
  logic [LINE_W-1:0]   alu_a, alu_b, alu_c;
  alu_res_t            alu_res;
  logic [7:0]          rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // Item decode: store the byte, detect a split, decide on a flush.
  always_comb begin
    ws        = is_ws(in_text_byte);
    st_wr     = !ws && (word_cnt_r < CW'(WORD_DEPTH));
    cnt_store = st_wr ? word_cnt_r + CW'(1) : word_cnt_r;
    wl_ext    = LIM_W'(word_limit_r);
    if (wl_ext == '0) begin
      wl_eff = LIM_W'(1);
    end else if (wl_ext > LIM_W'(WORD_DEPTH)) begin
      wl_eff = LIM_W'(WORD_DEPTH);
    end else begin
      wl_eff = wl_ext;
    end
    split       = !ws && (LIM_W'(cnt_store) >= wl_eff);
    first_flush = ws ? (!in_gap_r && ((word_cnt_r != '0) || !seen_first_r)) : split;
    cnt_after   = cnt_store;
    flush       = first_flush || (in_end_of_text && (cnt_after != '0));
  end

  // Word store.
  glf_store #(
    .DEPTH (WORD_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc && st_wr),
    .wr_addr (word_cnt_r[AW-1:0]),
    .wr_data (in_text_byte),
    .rd_addr (idx_nxt[AW-1:0]),
    .rd_data (rd_data)
  );

  // Shared add and compare unit.
  glf_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .res (alu_res)
  );

  assign load = !out_valid_r || !out_stall;

  // Sequencer: next state, unit operands and the byte to emit.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    base_nxt  = base_r;
    emit      = 1'b0;
    emit_byte = CH_SP;
    emit_last = 1'b0;
    alu_a     = line_r;
    alu_b     = LINE_W'(len_r);
    alu_c     = LINE_W'(line_limit_r);
    case (state_r)
      ST_IDLE: begin
        if (in_acc && flush) begin
          state_nxt = ST_PREP;
          idx_nxt   = '0;
        end
      end
      ST_PREP: begin
        // Line length plus word length against the line limit.
        base_nxt = alu_res.gt ? LINE_W'(len_r) : alu_res.sum[LINE_W-1:0];
        if (alu_res.gt) begin
          state_nxt = ST_NL;
        end else if (len_r != '0) begin
          state_nxt = ST_WORD;
        end else begin
          state_nxt = ST_SPACE;
        end
      end
      ST_NL: begin
        if (load) begin
          emit      = 1'b1;
          emit_byte = CH_LF;
          state_nxt = (len_r != '0) ? ST_WORD : ST_SPACE;
        end
      end
      ST_WORD: begin
        // Step the read index; stop when it reaches the word length.
        alu_a = LINE_W'(idx_r);
        alu_b = LINE_W'(1);
        alu_c = LINE_W'(len_r);
        if (load) begin
          emit      = 1'b1;
          emit_byte = rd_data;
          idx_nxt   = alu_res.sum[CW-1:0];
          if (alu_res.eq) begin
            state_nxt = ST_SPACE;
          end
        end
      end
      ST_SPACE: begin
        // New line length counts the trailing space.
        alu_a = base_r;
        alu_b = LINE_W'(1);
        if (load) begin
          emit      = 1'b1;
          emit_byte = CH_SP;
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers and text state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= LINE_LIMIT_RST;
      word_limit_r <= WORD_LIMIT_RST;
      word_cnt_r   <= '0;
      line_r       <= '0;
      in_gap_r     <= 1'b0;
      seen_first_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LINE_LIMIT: line_limit_r <= cfg_data;
          REG_WORD_LIMIT: word_limit_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (in_end_of_text) begin
          word_cnt_r   <= '0;
          in_gap_r     <= 1'b0;
          seen_first_r <= 1'b0;
          if (!flush) begin
            line_r <= '0;
          end
        end else begin
          word_cnt_r   <= flush ? '0 : cnt_after;
          in_gap_r     <= ws || split;
          seen_first_r <= 1'b1;
        end
      end
      if ((state_r == ST_SPACE) && load) begin
        line_r <= end_r ? '0 : alu_res.sum[LINE_W-1:0];
      end
    end
  end

  // Per-flush working registers.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    base_r <= base_nxt;
    if (in_acc) begin
      len_r <= cnt_after;
      end_r <= in_end_of_text;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

  // Checks.
`include "greedy_line_filler_top_assert.svh"

  `GLF_ASSERT_ALWAYS(a_cnt_range, word_cnt_r <= CW'(WORD_DEPTH))
  `GLF_ASSERT_ALWAYS(a_last_is_space, !out_valid_r || (out_last_r == (out_byte_r == CH_SP)))
  `GLF_ASSERT_ALWAYS(a_word_nonempty, (state_r != ST_WORD) || (len_r != '0))
  `GLF_ASSERT_NEXT(a_end_clears, in_acc && in_end_of_text, (word_cnt_r == '0) && !seen_first_r && !in_gap_r)

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// Greedy line filler testbench
// Drives text bytes into the line filler and checks every output byte. A
// scoreboard class models the word store and line length and lists the
// bytes that each input item should produce. The input idles and the output
// stalls at random. The register settings run across their extremes.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import glf_pkg::*;

  localparam int DEPTH = 32;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int NUM_PHASES = 7;
  // Register indexes that map to no register.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // One expected output byte.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } wrap_out_t;

  // Models the line filler and holds the bytes it still owes.
  class wrap_checker;
    logic [7:0] word_buf[DEPTH];
    int         word_len;
    int         line_len;
    bit         in_ws_run;
    bit         started;
    logic [7:0] line_lim;
    logic [5:0] word_lim;
    wrap_out_t  wrapped_q[$];
    logic [7:0] burst_q[$];
    int         err_cnt;

    function new();
      line_lim = LINE_LIMIT_RST;
      word_lim = WORD_LIMIT_RST;
      err_cnt = 0;
      clear_text();
    endfunction

    function void clear_text();
      word_len = 0;
      line_len = 0;
      in_ws_run = 0;
      started = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      if (idx == REG_LINE_LIMIT) line_lim = data;
      else if (idx == REG_WORD_LIMIT) word_lim = data[5:0];
    endfunction

    // Word length at which a word is split, clamped to the store depth.
    function int split_len();
      if (word_lim == 0) return 1;
      if (word_lim > DEPTH) return DEPTH;
      return word_lim;
    endfunction

    // Emits the held word, with a newline ahead of it when the line is full.
    function void flush_word();
      int sum;
      sum = line_len + word_len;
      if (sum > line_lim) begin
        burst_q.push_back(CH_LF);
        sum = word_len;
      end
      for (int i = 0; i < word_len; i++) burst_q.push_back(word_buf[i]);
      burst_q.push_back(CH_SP);
      line_len = (sum + 1) & 'h1FF;
      word_len = 0;
    endfunction

    // Works out the bytes caused by one accepted input item.
    function void note_byte(logic [7:0] b, logic eot);
      bit ws;
      ws = (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
      burst_q.delete();
      if (ws) begin
        if (!in_ws_run && (word_len != 0 || !started)) flush_word();
        in_ws_run = 1;
      end else begin
        in_ws_run = 0;
        if (word_len < DEPTH) begin
          word_buf[word_len] = b;
          word_len++;
        end
        if (word_len >= split_len()) begin
          flush_word();
          in_ws_run = 1;
        end
      end
      started = 1;
      if (eot) begin
        if (word_len != 0) flush_word();
        clear_text();
      end
      foreach (burst_q[i])
        wrapped_q.push_back('{burst_q[i], i == burst_q.size() - 1});
    endfunction

    function int pending();
      return wrapped_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_cnt++;
    endtask

    // Compares one accepted output item with the oldest expected byte.
    task check_char(logic [7:0] ch, logic last);
      wrap_out_t want;
      if (wrapped_q.size() == 0) begin
        report($sformatf("output byte %02h with nothing expected", ch));
      end else begin
        want = wrapped_q.pop_front();
        if (ch !== want.ch)
          report($sformatf("out_byte %02h, expected %02h", ch, want.ch));
        if (last !== want.last)
          report($sformatf("out_run_last %b, expected %b (byte %02h)",
                           last, want.last, want.ch));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_text_byte = 8'h00;
  logic                 in_end_of_text = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_run_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_LIMIT;
  logic [7:0]           cfg_data = 8'h00;

  wrap_checker sb;
  bit          quiet = 0;
  bit          hold_req = 0;
  int          cycle_cnt = 0;

  greedy_line_filler_top #(.WORD_DEPTH(DEPTH)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // Offers one text item after a random gap and waits for it to be taken.
  task send_item(logic [7:0] b, logic eot);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, eot);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Stops offering text and waits until the block has gone quiet.
  task wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Text-like stimulus: words with random content, whitespace runs, noise.
  task random_text(int n);
    int         cnt;
    int         r;
    int         len;
    logic [7:0] b;
    logic       eot;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      end else if (r < 90) begin
        len = $urandom_range(1, 3);
      end else begin
        len = 1;
      end
      for (int i = 0; i < len && cnt < n; i++) begin
        if (r < 65) begin
          if ($urandom_range(0, 4) == 0) b = 8'($urandom_range(0, 255));
          else b = 8'h61 + 8'($urandom_range(0, 25));
        end else if (r < 90) begin
          case ($urandom_range(0, 3))
            0: b = CH_SP;
            1: b = CH_TAB;
            2: b = CH_CR;
            default: b = CH_LF;
          endcase
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        cnt++;
        if (cnt == n) eot = 1'($urandom_range(0, 1));
        else eot = ($urandom_range(0, 39) == 0);
        send_item(b, eot);
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int stall_left;
    int free_left;
    int hold_left;
    stall_left = 0;
    free_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        free_left = $urandom_range(0, 12);
        stall_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Output checks and the run limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) sb.check_char(out_byte, out_run_last);
  end

  initial begin
    logic [7:0] ll;
    logic [7:0] wl;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Leading whitespace gives one lone space; the rest of the run collapses.
    send_item(CH_SP, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    // A word with extreme byte values.
    send_item("H", 1'b0);
    send_item("i", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(CH_SP, 1'b0);
    // End of text with an open word, then after trailing whitespace.
    send_item("x", 1'b1);
    send_item("a", 1'b0);
    send_item(CH_SP, 1'b0);
    send_item(CH_LF, 1'b1);
    send_item(CH_TAB, 1'b1);

    // Split at three bytes, and a zero line limit forces newlines.
    wait_idle();
    write_reg(REG_LINE_LIMIT, 8'd0);
    write_reg(REG_WORD_LIMIT, 8'd3);
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    send_item("c", 1'b0);
    send_item(CH_SP, 1'b0);
    send_item("d", 1'b1);

    // A zero word limit acts as one; spare indexes are ignored.
    wait_idle();
    write_reg(REG_LINE_LIMIT, 8'd255);
    write_reg(REG_WORD_LIMIT, 8'd0);
    write_reg(REG_SPARE_A, 8'h01);
    write_reg(REG_SPARE_B, 8'hFF);
    send_item("q", 1'b0);
    send_item("r", 1'b0);
    send_item(CH_SP, 1'b1);

    // Random text across a range of settings.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin ll = 8'd255; wl = 8'd32; end
        1: begin ll = 8'd1; wl = 8'd1; end
        2: begin ll = 8'd0; wl = 8'd63; end
        3: begin ll = 8'd20; wl = 8'd5; end
        6: begin ll = LINE_LIMIT_RST; wl = WORD_LIMIT_RST; end
        default: begin
          ll = 8'($urandom_range(0, 255));
          wl = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(REG_LINE_LIMIT, ll);
      write_reg(REG_WORD_LIMIT, wl);
      if (ph == 4) begin
        write_reg(REG_SPARE_A, 8'($urandom_range(0, 255)));
        write_reg(REG_SPARE_B, 8'($urandom_range(0, 255)));
      end
      // One phase with no idling at all, one with a long output hold-off.
      quiet = (ph == 2);
      if (ph == 3) hold_req = 1;
      random_text(ITEMS_PER_PHASE);
    end

    wait_idle();
    if (sb.err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
